// File: rtl/dps_pkg.sv
// Shared types, codes and defaults for the dynamic priority scheduler.
`default_nettype none

package dps_pkg;

  localparam int MAX_PROCESSES_DEF = 16;

  // Operation carried by an input transfer.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic signed [7:0] PRI_MIN = -8'sd128;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REQUEUED = 3'd1,
    ST_FINISHED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } dps_status_t;

  typedef struct packed {
    logic [7:0]        id;
    logic signed [7:0] pri;
    logic [7:0]        need;
    logic [7:0]        run;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic        capture;     // latch the input item as the insert candidate
    logic        pop;         // take the head entry, requeue candidate from it
    logic        seed;        // start an insert walk at the tail
    logic        walk;        // one walk step: shift one entry or place candidate
    logic        set_status;  // load the result status code
    dps_status_t code;
    logic        load_out;    // move the result into the output register
  } dps_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic retire;
    logic walk_shift;
    logic out_free;
  } dps_sts_t;

endpackage

`default_nettype wire

// File: rtl/dps_in_if.sv
// Input channel of the scheduler: one add or tick command per transfer.
`default_nettype none

interface dps_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [7:0]        process_id;
  logic signed [7:0] priority_req;
  logic [7:0]        need_time;

  modport source (output valid, command, process_id, priority_req, need_time,
                  input ready);
  modport sink   (input valid, command, process_id, priority_req, need_time,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/dps_out_if.sv
// Result channel of the scheduler: one result per command.
`default_nettype none

interface dps_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [7:0]        ran_id;
  logic signed [7:0] ran_priority;
  logic [7:0]        run_time;
  logic [4:0]        queue_count;

  modport source (output valid, status, ran_id, ran_priority, run_time, queue_count,
                  input ready);
  modport sink   (input valid, status, ran_id, ran_priority, run_time, queue_count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/dps_ctrl.sv
// Sequencing controller of the scheduler: accept, pop, insert walk, respond.
`default_nettype none

module dps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  input  dps_pkg::dps_sts_t sts,
  output dps_pkg::dps_cmd_t cmd
);
  import dps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POPD,
    S_SEED,
    S_WALK,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_ready && in_valid;

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_ADDED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture    = 1'b1;
          cmd.set_status = 1'b1;
          if (in_command == CMD_ADD) begin
            if (sts.full) begin
              cmd.code   = ST_FULL;
              state_next = S_RESP;
            end else begin
              cmd.code   = ST_ADDED;
              state_next = S_SEED;
            end
          end else if (sts.empty) begin
            cmd.code   = ST_EMPTY;
            state_next = S_RESP;
          end else begin
            cmd.code   = ST_REQUEUED;
            state_next = S_POPD;
          end
        end
      end
      S_POPD: begin
        cmd.pop        = 1'b1;
        cmd.set_status = 1'b1;
        if (sts.retire) begin
          cmd.code   = ST_FINISHED;
          state_next = S_RESP;
        end else begin
          cmd.code   = ST_REQUEUED;
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.walk_shift) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: rtl/dps_datapath.sv
// Queue memory, pointers, insert walk and result registers of the scheduler.
`default_nettype none

module dps_datapath #(
  parameter int MAX_PROCESSES = dps_pkg::MAX_PROCESSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dps_pkg::dps_cmd_t cmd,
  output dps_pkg::dps_sts_t sts,
  input  logic [7:0]        process_id,
  input  logic signed [7:0] priority_req,
  input  logic [7:0]        need_time,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [2:0]        status,
  output logic [7:0]        ran_id,
  output logic signed [7:0] ran_priority,
  output logic [7:0]        run_time,
  output logic [4:0]        queue_count
);
  import dps_pkg::*;

  localparam int PW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam logic [PW-1:0] LAST = PW'(MAX_PROCESSES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PROCESSES);

  // Circular queue sorted by descending priority from head to tail.
  entry_t mem [MAX_PROCESSES];
  entry_t rdata;
  entry_t wdata;
  logic   we;
  logic [PW-1:0] raddr;

  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [PW-1:0] wp;     // slot being filled by the walk
  logic [CW-1:0] wk;     // entries still ahead of the walk
  entry_t        cand;

  dps_status_t       res_status;
  logic [7:0]        res_id;
  logic signed [7:0] res_pri;
  logic [7:0]        res_run;

  logic [PW-1:0] wp_prev;
  logic [PW-1:0] wp_prev2;
  logic [PW-1:0] tail_prev;
  logic [PW-1:0] tail_inc;
  logic [PW-1:0] head_inc;
  logic [7:0]    run_inc;
  logic          shift;

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] x);
    return (x == '0) ? LAST : x - PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] x);
    return (x == LAST) ? '0 : x + PW'(1);
  endfunction

  assign wp_prev   = ring_prev(wp);
  assign wp_prev2  = ring_prev(wp_prev);
  assign tail_prev = ring_prev(tail);
  assign tail_inc  = ring_next(tail);
  assign head_inc  = ring_next(head);
  assign run_inc   = rdata.run + 8'd1;
  assign shift     = (wk != '0) && (cand.pri > rdata.pri);

  always_comb begin
    if (cmd.seed) begin
      raddr = tail_prev;
    end else if (cmd.walk) begin
      raddr = wp_prev2;
    end else begin
      raddr = head;
    end
  end

  assign we    = cmd.walk;
  assign wdata = shift ? rdata : cand;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign sts.full       = (count == FULL_COUNT);
  assign sts.empty      = (count == '0);
  assign sts.retire     = (run_inc >= rdata.need);
  assign sts.walk_shift = shift;
  assign sts.out_free   = !rsp_valid || rsp_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.pop) begin
        head  <= head_inc;
        count <= count - CW'(1);
      end else if (cmd.walk && !shift) begin
        tail  <= tail_inc;
        count <= count + CW'(1);
      end
    end
  end

  // Walk state, candidate and result fields.
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      wp <= tail;
      wk <= count;
    end else if (cmd.walk && shift) begin
      wp <= wp_prev;
      wk <= wk - CW'(1);
    end
    if (cmd.capture) begin
      cand.id   <= process_id;
      cand.pri  <= priority_req;
      cand.need <= need_time;
      cand.run  <= 8'd0;
      res_id    <= 8'd0;
      res_pri   <= 8'sd0;
      res_run   <= 8'd0;
    end else if (cmd.pop) begin
      cand.id   <= rdata.id;
      cand.pri  <= (rdata.pri == PRI_MIN) ? PRI_MIN : rdata.pri - 8'sd1;
      cand.need <= rdata.need;
      cand.run  <= run_inc;
      res_id    <= rdata.id;
      res_pri   <= rdata.pri;
      res_run   <= run_inc;
    end
    if (cmd.set_status) begin
      res_status <= cmd.code;
    end
  end

  // Output register: hold until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      ran_id       <= res_id;
      ran_priority <= res_pri;
      run_time     <= res_run;
      queue_count  <= 5'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue fill level above capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from an empty queue");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && !shift) |-> count != FULL_COUNT)
    else $error("insert into a full queue");

  a_walk_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> wk <= count)
    else $error("insert walk passed the head");
`endif

endmodule

`default_nettype wire

// File: rtl/dynamic_priority_scheduler.sv
// Flow: a full or empty result goes straight to the response step; an add seeds and runs
// the insert walk, which shifts back the queued entries of lower priority (0..N-1 of them);
// a tick pops the head and either retires it or requeues it through the same walk. One entry
// per cycle is moved by the insert walk over the queue memory, which has one read and one write port.
// The next item is taken once the result is registered.
// Reset clears state, head, tail, fill level and result valid; the queue memory is not cleared.
`default_nettype none

module dynamic_priority_scheduler #(
  parameter int MAX_PROCESSES = dps_pkg::MAX_PROCESSES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  dps_in_if.sink        request,
  dps_out_if.source     response
);
  import dps_pkg::*;

  dps_cmd_t cmd;
  dps_sts_t sts;
  logic     in_ready;

  // The controller sees only the handshake and the command bit; the payload
  // goes straight to the datapath, which latches it on the accepting transfer.
  dps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_command (request.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  assign request.ready = in_ready;

  // Queue storage, insert walk and the output register that holds a result
  // until its transfer completes.
  dps_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .process_id   (request.process_id),
    .priority_req (request.priority_req),
    .need_time    (request.need_time),
    .rsp_valid    (response.valid),
    .rsp_ready    (response.ready),
    .status       (response.status),
    .ran_id       (response.ran_id),
    .ran_priority (response.ran_priority),
    .run_time     (response.run_time),
    .queue_count  (response.queue_count)
  );

endmodule

`default_nettype wire

// File: dv/tb_dynamic_priority_scheduler.sv
// Self-checking testbench for the dynamic priority scheduler with a built-in predictor.
`timescale 1ns / 1ps

module tb_dynamic_priority_scheduler;
  import dps_pkg::*;

  localparam int NPROC        = MAX_PROCESSES_DEF;
  // Longest idle stretch: receiver hold-off plus one item plus a gap.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 3 * (NPROC + 3);
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 250;

  // One command offered on the request channel.
  typedef struct {
    logic              cmd;
    logic [7:0]        id;
    logic signed [7:0] pri;
    logic [7:0]        need;
  } sched_cmd_t;

  // One result as it should appear on the response channel.
  typedef struct {
    dps_status_t       status;
    logic [7:0]        ran_id;
    logic signed [7:0] ran_pri;
    logic [7:0]        run_time;
    logic [4:0]        count;
  } slice_result_t;

  logic clk;
  logic rst;

  dps_in_if  request_if ();
  dps_out_if response_if ();

  dynamic_priority_scheduler #(.MAX_PROCESSES(NPROC)) uut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_if),
    .response (response_if)
  );

  sched_cmd_t    pending_cmds[$];
  slice_result_t due_results[$];

  // Shadow copy of the ready queue, head at index 0.
  entry_t      shadow_entries[NPROC];
  int unsigned shadow_fill;

  int mismatches;
  int results_seen;
  bit in_took;

  // Sender burst state.
  int burst_left;
  int gap_left;

  // Receiver stall state.
  int       rx_mode;
  int       rx_mode_left;
  int       rx_phase;
  int       rx_hold_left;
  int       next_hold_at;
  bit [7:0] rx_pattern;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: insert behind every entry of equal or higher priority, so equal
  // priorities stay first-in first-out.
  // ---------------------------------------------------------------------------
  function automatic void enqueue_by_priority(entry_t e);
    int pos;
    pos = 0;
    if (shadow_fill >= NPROC) return;
    while (pos < shadow_fill && !($signed(e.pri) > $signed(shadow_entries[pos].pri)))
      pos++;
    for (int k = shadow_fill; k > pos; k--)
      shadow_entries[k] = shadow_entries[k - 1];
    shadow_entries[pos] = e;
    shadow_fill++;
  endfunction

  // Apply one accepted command to the shadow queue and queue up its result.
  function automatic void sched_apply(sched_cmd_t c);
    slice_result_t r;
    entry_t        head;
    entry_t        back;
    r.status   = ST_ADDED;
    r.ran_id   = '0;
    r.ran_pri  = '0;
    r.run_time = '0;
    if (c.cmd == CMD_ADD) begin
      if (shadow_fill >= NPROC) begin
        r.status = ST_FULL;
      end else begin
        head.id   = c.id;
        head.pri  = c.pri;
        head.need = c.need;
        head.run  = '0;
        enqueue_by_priority(head);
        r.status = ST_ADDED;
      end
    end else if (shadow_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Pop the head and advance its run count; the count wraps at 8 bits.
      head = shadow_entries[0];
      for (int k = 1; k < shadow_fill; k++)
        shadow_entries[k - 1] = shadow_entries[k];
      shadow_fill--;
      head.run   = head.run + 8'd1;
      r.ran_id   = head.id;
      r.ran_pri  = head.pri;
      r.run_time = head.run;
      // Retire once the run count reaches or passes the needed time.
      if (head.run >= head.need) begin
        r.status = ST_FINISHED;
      end else begin
        back = head;
        // Lower the priority by one, holding at the floor.
        if (head.pri != PRI_MIN) back.pri = head.pri - 8'sd1;
        enqueue_by_priority(back);
        r.status = ST_REQUEUED;
      end
    end
    r.count = shadow_fill[4:0];
    due_results.push_back(r);
  endfunction

  function automatic void push_cmd(logic cmd, logic [7:0] id, logic signed [7:0] pri,
                                   logic [7:0] need);
    sched_cmd_t c;
    c.cmd  = cmd;
    c.id   = id;
    c.pri  = pri;
    c.need = need;
    pending_cmds.push_back(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random phases with a varying add/tick
  // mix so the queue swings between empty, partly filled and full.
  // ---------------------------------------------------------------------------
  initial begin
    int                add_pct;
    int                phase_len;
    int                made;
    int                sel;
    logic              cmd;
    logic signed [7:0] pri;
    logic [7:0]        need;

    rst                      = 1'b1;
    request_if.valid         = 1'b0;
    request_if.command       = CMD_ADD;
    request_if.process_id    = '0;
    request_if.priority_req  = '0;
    request_if.need_time     = '0;
    response_if.ready        = 1'b0;
    shadow_fill              = 0;
    mismatches               = 0;
    results_seen             = 0;
    in_took                  = 1'b0;
    burst_left               = 0;
    gap_left                 = 0;
    rx_mode                  = 0;
    rx_mode_left             = 0;
    rx_phase                 = 0;
    rx_hold_left             = 0;
    next_hold_at             = 300;
    rx_pattern               = 8'hA5;

    // Tick on an empty queue.
    push_cmd(CMD_TICK, 8'hFF, 8'sh7F, 8'hFF);
    // Extremes of id, priority and needed time.
    push_cmd(CMD_ADD, 8'h00, 8'sh7F, 8'd1);
    push_cmd(CMD_ADD, 8'hFF, -8'sd128, 8'd255);
    // Tie at the priority floor goes behind the earlier entry.
    push_cmd(CMD_ADD, 8'h55, -8'sd128, 8'd3);
    // Needed time of zero retires after the first slice.
    push_cmd(CMD_ADD, 8'h01, 8'sd5, 8'd0);
    // Fill to capacity with equal priorities.
    for (int i = 2; i < 14; i++)
      push_cmd(CMD_ADD, 8'(i), 8'sd5, 8'd2);
    // Add into a full queue is dropped.
    push_cmd(CMD_ADD, 8'hEE, 8'sh7F, 8'd1);
    for (int i = 0; i < 6; i++)
      push_cmd(CMD_TICK, 8'(i * 37), 8'(i * 51), 8'(i * 29));

    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0:       add_pct = 10;
        1:       add_pct = 35;
        2:       add_pct = 50;
        3:       add_pct = 65;
        default: add_pct = 90;
      endcase
      for (int i = 0; i < phase_len; i++) begin
        cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_TICK;
        // Cluster priorities so ties and the floor are hit often.
        sel = $urandom_range(0, 9);
        if (sel < 4)       pri = 8'(int'($urandom_range(0, 6)) - 3);
        else if (sel < 6)  pri = 8'(int'($urandom_range(0, 3)) - 128);
        else if (sel < 7)  pri = 8'(int'($urandom_range(124, 127)));
        else               pri = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel < 7)       need = 8'($urandom_range(1, 4));
        else if (sel < 9)  need = 8'($urandom_range(1, 20));
        else               need = 8'($urandom_range(1, 255));
        push_cmd(cmd, 8'($urandom_range(0, 255)), pri, need);
      end
      made += phase_len;
    end

    repeat (12) @(negedge clk);
    rst = 1'b0;

    while (pending_cmds.size() != 0 || due_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: predict on every request transfer, then offer the next command at
  // the falling edge. Valid stays up until the transfer completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took = !rst && request_if.valid && request_if.ready;
    if (in_took) sched_apply(pending_cmds.pop_front());
  end

  always @(negedge clk) begin
    if (rst) begin
      request_if.valid <= 1'b0;
    end else if (!(request_if.valid && !in_took)) begin
      if (in_took) burst_left--;
      // Pick the next burst: sometimes a long unbroken run, else short with gaps.
      if (burst_left <= 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = 40;
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left   = $urandom_range(1, 7);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        request_if.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        request_if.valid        <= 1'b1;
        request_if.command      <= pending_cmds[0].cmd;
        request_if.process_id   <= pending_cmds[0].id;
        request_if.priority_req <= pending_cmds[0].pri;
        request_if.need_time    <= pending_cmds[0].need;
      end else begin
        request_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a mode that is redrawn whenever its countdown runs out. At set points
  // it holds off for a long stretch while the sender keeps offering, so the
  // block backs up and drops request ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (!rst) begin
      if (rx_hold_left == 0 && results_seen >= next_hold_at) begin
        rx_hold_left = HOLD_CYCLES;
        next_hold_at += 700;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 3);
          rx_pattern   = 8'($urandom_range(0, 255)) | 8'h01;
          rx_mode_left = 48;
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 1) == 1);
          2:       rdy = ($urandom_range(0, 99) < 85);
          default: rdy = rx_pattern[rx_phase % 8];
        endcase
      end
    end
    response_if.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    slice_result_t want;
    if (!rst && response_if.valid && response_if.ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d id=%0d", $realtime,
                   response_if.status, response_if.ran_id);
      end else begin
        want = due_results.pop_front();
        if (response_if.status !== want.status || response_if.ran_id !== want.ran_id ||
            response_if.ran_priority !== want.ran_pri ||
            response_if.run_time !== want.run_time ||
            response_if.queue_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d expected st=%0d id=%0d pri=%0d run=%0d cnt=%0d,",
                     $realtime, results_seen, want.status, want.ran_id, want.ran_pri,
                     want.run_time, want.count,
                     " got st=%0d id=%0d pri=%0d run=%0d cnt=%0d",
                     response_if.status, response_if.ran_id,
                     response_if.ran_priority, response_if.run_time,
                     response_if.queue_count);
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (request_if.valid && request_if.ready) ||
          (response_if.valid && response_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
